@@ hdl/bbg_pkg.sv @@
// ----------------------------------------------------------------------------
// bbg_pkg
// Shared types, constants and tables of the backlight breathing generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bbg_pkg;

    // Defaults for the top level parameters
    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int FIRST_TICK_MS_DEF   = 24;

    // APB register file
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_PHASE_STEP = 3'd0,
        REG_BASE_MIN   = 3'd1,
        REG_BASE_MAX   = 3'd2,
        REG_DEPTH      = 3'd3,
        REG_BOOST      = 3'd4,
        REG_FILT_RATE  = 3'd5
    } reg_idx_t;

    localparam logic [23:0] PHASE_STEP_RST = 24'd631612;
    localparam logic [15:0] BASE_MIN_RST   = 16'd6554;
    localparam logic [15:0] BASE_MAX_RST   = 16'd47186;
    localparam logic [15:0] DEPTH_RST      = 16'd4260;
    localparam logic [15:0] BOOST_RST      = 16'd2294;
    localparam logic [15:0] FILT_RATE_RST  = 16'd144;

    typedef struct packed {
        logic [23:0] phase_step;
        logic [15:0] base_min;
        logic [15:0] base_max;
        logic [15:0] depth;
        logic [15:0] boost;
        logic [15:0] filt_rate;
    } cfg_t;

    // Request codes
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_ON      = 2'd1,
        REQ_OFF     = 2'd2,
        REQ_RESTART = 2'd3
    } req_type_t;

    // Arithmetic constants
    localparam logic [6:0]  DT_MIN           = 7'd5;
    localparam logic [6:0]  DT_MAX           = 7'd80;
    localparam logic [6:0]  FULL_PERCENT     = 7'd100;
    localparam logic [15:0] BIAS_ON          = 16'h7FFF;
    localparam logic [15:0] BIAS_OFF         = 16'h8000;
    localparam logic [15:0] BIAS_FLOOR       = 16'd65;
    localparam logic [15:0] ON_MIN_DELTA     = 16'd15729;
    localparam logic [15:0] ON_HEADROOM_GAIN = 16'd18350;
    localparam logic [15:0] OFF_MIN_DELTA    = 16'd11796;
    localparam logic [15:0] OFF_LEVEL_GAIN   = 16'd10486;
    localparam logic [16:0] SINE_C0          = 17'd102944;
    localparam logic [16:0] SINE_C1          = 17'd42334;
    localparam logic [16:0] SINE_C2          = 17'd5223;
    localparam logic [16:0] SINE_C3          = 17'd307;
    localparam logic [16:0] Q16_ONE          = 17'h10000;
    localparam logic [16:0] WAVE_MID         = 17'h08000;
    localparam logic [25:0] LEVEL_ROUND      = 26'd32768;
    // floor(x/100) = (x * ceil(2^30/100)) >> 30, exact for x below 2^23
    localparam logic [23:0] DIV100_MAGIC     = 24'd10737419;
    localparam logic [31:0] DECAY_PER_MS     = 32'd1072829531;

    // Decay table: exp(-0.00085*k) in Q1.30, k = 0..80
    localparam int DECAY_DEPTH = 81;
    typedef logic [DECAY_DEPTH-1:0][30:0] decay_rom_t;

    function automatic decay_rom_t decay_rom_build();
        decay_rom_t  rom;
        logic [63:0] acc;
        rom[0] = 31'h4000_0000;
        for (int k = 1; k < DECAY_DEPTH; k++) begin
            acc    = 64'(rom[k-1]) * 64'(DECAY_PER_MS) + 64'h2000_0000;
            rom[k] = acc[60:30];
        end
        return rom;
    endfunction

    localparam decay_rom_t DECAY_ROM = decay_rom_build();

    // Controller to datapath
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_PHASE,
        MUL_BMIN,
        MUL_BMAX,
        MUL_T2,
        MUL_DIV,
        MUL_P1,
        MUL_ALPHA,
        MUL_T2P,
        MUL_QS,
        MUL_DEPTH,
        MUL_FILT,
        MUL_FAC,
        MUL_BIAS,
        MUL_DECAY
    } mul_sel_t;

    typedef enum logic [4:0] {
        WB_NONE,
        WB_PHASE,
        WB_BMIN,
        WB_BMAX,
        WB_T2,
        WB_DIV,
        WB_P1,
        WB_ALPHA,
        WB_P2,
        WB_P3,
        WB_WAVE,
        WB_TGT,
        WB_ABS,
        WB_FILT,
        WB_FAC,
        WB_LVL,
        WB_DECAY
    } wb_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        wb_sel_t  wb_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/bbg_regs.sv @@
// ----------------------------------------------------------------------------
// bbg_regs
// APB register file holding the six configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bbg_regs
    import bbg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_step <= PHASE_STEP_RST;
            cfg_reg.base_min   <= BASE_MIN_RST;
            cfg_reg.base_max   <= BASE_MAX_RST;
            cfg_reg.depth      <= DEPTH_RST;
            cfg_reg.boost      <= BOOST_RST;
            cfg_reg.filt_rate  <= FILT_RATE_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_PHASE_STEP: cfg_reg.phase_step <= pwdata[23:0];
                REG_BASE_MIN:   cfg_reg.base_min   <= pwdata[15:0];
                REG_BASE_MAX:   cfg_reg.base_max   <= pwdata[15:0];
                REG_DEPTH:      cfg_reg.depth      <= pwdata[15:0];
                REG_BOOST:      cfg_reg.boost      <= pwdata[15:0];
                REG_FILT_RATE:  cfg_reg.filt_rate  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PHASE_STEP: prdata = APB_DATA_W'(cfg_reg.phase_step);
            REG_BASE_MIN:   prdata = APB_DATA_W'(cfg_reg.base_min);
            REG_BASE_MAX:   prdata = APB_DATA_W'(cfg_reg.base_max);
            REG_DEPTH:      prdata = APB_DATA_W'(cfg_reg.depth);
            REG_BOOST:      prdata = APB_DATA_W'(cfg_reg.boost);
            REG_FILT_RATE:  prdata = APB_DATA_W'(cfg_reg.filt_rate);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bbg_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbg_ctrl
// Sequencer: walks a tick through the shared multiplier schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module bbg_ctrl
    import bbg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] s_req_type,
    output logic            s_ready,
    input  dp_status_t      status,
    output dp_cmd_t         cmd
);

    // Most states issue one product and/or retire the previous one
    typedef enum logic [24:0] {
        ST_IDLE   = 25'h0000001,
        ST_PHASE  = 25'h0000002,
        ST_BMIN   = 25'h0000004,
        ST_BMAX   = 25'h0000008,
        ST_T2     = 25'h0000010,
        ST_DIV    = 25'h0000020,
        ST_P1     = 25'h0000040,
        ST_ALPHA  = 25'h0000080,
        ST_P2     = 25'h0000100,
        ST_P2W    = 25'h0000200,
        ST_P3     = 25'h0000400,
        ST_P3W    = 25'h0000800,
        ST_QS     = 25'h0001000,
        ST_WAVE   = 25'h0002000,
        ST_DEPTH  = 25'h0004000,
        ST_TGT    = 25'h0008000,
        ST_ABS    = 25'h0010000,
        ST_FILT_M = 25'h0020000,
        ST_FILT   = 25'h0040000,
        ST_FAC_M  = 25'h0080000,
        ST_FAC    = 25'h0100000,
        ST_BIAS_M = 25'h0200000,
        ST_LVL    = 25'h0400000,
        ST_DECAY  = 25'h0800000,
        ST_OUT    = 25'h1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.mul_sel  = MUL_NONE;
        cmd.wb_sel   = WB_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_req_type == REQ_TICK) begin
                        state_next = ST_PHASE;
                    end
                end
            end
            ST_PHASE: begin
                cmd.mul_sel = MUL_PHASE;
                state_next  = ST_BMIN;
            end
            ST_BMIN: begin
                cmd.mul_sel = MUL_BMIN;
                cmd.wb_sel  = WB_PHASE;
                state_next  = ST_BMAX;
            end
            ST_BMAX: begin
                cmd.mul_sel = MUL_BMAX;
                cmd.wb_sel  = WB_BMIN;
                state_next  = ST_T2;
            end
            ST_T2: begin
                cmd.mul_sel = MUL_T2;
                cmd.wb_sel  = WB_BMAX;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.mul_sel = MUL_DIV;
                cmd.wb_sel  = WB_T2;
                state_next  = ST_P1;
            end
            ST_P1: begin
                cmd.mul_sel = MUL_P1;
                cmd.wb_sel  = WB_DIV;
                state_next  = ST_ALPHA;
            end
            ST_ALPHA: begin
                cmd.mul_sel = MUL_ALPHA;
                cmd.wb_sel  = WB_P1;
                state_next  = ST_P2;
            end
            ST_P2: begin
                cmd.mul_sel = MUL_T2P;
                cmd.wb_sel  = WB_ALPHA;
                state_next  = ST_P2W;
            end
            ST_P2W: begin
                cmd.wb_sel = WB_P2;
                state_next = ST_P3;
            end
            ST_P3: begin
                cmd.mul_sel = MUL_T2P;
                state_next  = ST_P3W;
            end
            ST_P3W: begin
                cmd.wb_sel = WB_P3;
                state_next = ST_QS;
            end
            ST_QS: begin
                cmd.mul_sel = MUL_QS;
                state_next  = ST_WAVE;
            end
            ST_WAVE: begin
                cmd.wb_sel = WB_WAVE;
                state_next = ST_DEPTH;
            end
            ST_DEPTH: begin
                cmd.mul_sel = MUL_DEPTH;
                state_next  = ST_TGT;
            end
            ST_TGT: begin
                cmd.wb_sel = WB_TGT;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                cmd.wb_sel = WB_ABS;
                state_next = ST_FILT_M;
            end
            ST_FILT_M: begin
                cmd.mul_sel = MUL_FILT;
                state_next  = ST_FILT;
            end
            ST_FILT: begin
                cmd.wb_sel = WB_FILT;
                state_next = ST_FAC_M;
            end
            ST_FAC_M: begin
                cmd.mul_sel = MUL_FAC;
                state_next  = ST_FAC;
            end
            ST_FAC: begin
                cmd.wb_sel = WB_FAC;
                state_next = ST_BIAS_M;
            end
            ST_BIAS_M: begin
                cmd.mul_sel = MUL_BIAS;
                state_next  = ST_LVL;
            end
            ST_LVL: begin
                cmd.mul_sel = MUL_DECAY;
                cmd.wb_sel  = WB_LVL;
                state_next  = ST_DECAY;
            end
            ST_DECAY: begin
                cmd.wb_sel = WB_DECAY;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!status.out_stall) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bbg_dp.sv @@
// ----------------------------------------------------------------------------
// bbg_dp
// Datapath: state registers, one shared 32x32 multiplier, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbg_dp
    import bbg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int FIRST_TICK_MS   = FIRST_TICK_MS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  dp_cmd_t         cmd,
    output dp_status_t      status,
    input  cfg_t            cfg,
    input  wire logic [1:0] s_req_type,
    input  wire logic [7:0] s_elapsed_ms,
    input  wire logic [6:0] s_brightness_percent,
    input  wire logic       s_audio_playing,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [9:0] m_drive_level
);

    localparam int QB  = SINE_TABLE_BITS - 2;
    localparam int PAD = 16 - QB;
    localparam logic [7:0] FIRST_MS = 8'(FIRST_TICK_MS);

    // model state
    logic [31:0] phase_reg;
    logic [15:0] filt_reg;
    logic [15:0] bias_reg;
    logic        seeded_reg;
    // per-tick working registers
    logic [6:0]  dt_reg;
    logic [6:0]  bp_reg;
    logic        aud_reg;
    logic [22:0] bsum_reg;
    logic [15:0] base_reg;
    logic [16:0] t2_reg;
    logic [16:0] p_reg;
    logic [16:0] alpha_reg;
    logic [16:0] wave_reg;
    logic [15:0] tgt_reg;
    logic [15:0] diff_reg;
    logic        up_reg;
    logic [15:0] fac_reg;
    logic [15:0] lvl_reg;
    logic [63:0] prod_reg;
    logic [9:0]  out_reg;
    logic        m_valid_reg;

    logic [7:0]  dt_src;
    logic [6:0]  dt_clamped;
    logic [6:0]  bp_clamped;
    logic [15:0] t_raw;
    logic [16:0] t_val;
    logic        bias_neg;
    logic        bias_pos;
    logic [15:0] bias_mag;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [15:0] qs_sat;
    logic [15:0] qs_half;
    logic [17:0] tgt_sum;
    logic [16:0] bias_d;
    logic [16:0] lvl_up;
    logic [15:0] decay_val;
    logic [25:0] lvl_scaled;

    // dt and brightness clamps at item entry
    assign dt_src = seeded_reg ? s_elapsed_ms : FIRST_MS;
    assign dt_clamped = (dt_src < 8'(DT_MIN)) ? DT_MIN :
                        (dt_src > 8'(DT_MAX)) ? DT_MAX : dt_src[6:0];
    assign bp_clamped = (s_brightness_percent > FULL_PERCENT) ? FULL_PERCENT
                                                              : s_brightness_percent;

    // quarter-wave argument; phase[31:30] is the quadrant
    assign t_raw = {phase_reg[29 -: QB], {PAD{1'b0}}};
    assign t_val = phase_reg[30] ? (Q16_ONE - {1'b0, t_raw}) : {1'b0, t_raw};

    assign bias_neg = bias_reg[15];
    assign bias_pos = !bias_reg[15] && (bias_reg != 16'd0);
    assign bias_mag = bias_neg ? (16'd0 - bias_reg) : bias_reg;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_PHASE: begin
                mul_a = 32'(cfg.phase_step);
                mul_b = 32'(dt_reg);
            end
            MUL_BMIN: begin
                mul_a = 32'(cfg.base_min);
                mul_b = 32'(FULL_PERCENT - bp_reg);
            end
            MUL_BMAX: begin
                mul_a = 32'(cfg.base_max);
                mul_b = 32'(bp_reg);
            end
            MUL_T2: begin
                mul_a = 32'(t_val);
                mul_b = 32'(t_val);
            end
            MUL_DIV: begin
                mul_a = 32'(bsum_reg);
                mul_b = 32'(DIV100_MAGIC);
            end
            MUL_P1: begin
                mul_a = 32'(t2_reg);
                mul_b = 32'(SINE_C3);
            end
            MUL_ALPHA: begin
                mul_a = 32'(cfg.filt_rate);
                mul_b = 32'(dt_reg);
            end
            MUL_T2P: begin
                mul_a = 32'(t2_reg);
                mul_b = 32'(p_reg);
            end
            MUL_QS: begin
                mul_a = 32'(t_val);
                mul_b = 32'(p_reg);
            end
            MUL_DEPTH: begin
                mul_a = 32'(cfg.depth);
                mul_b = 32'(wave_reg);
            end
            MUL_FILT: begin
                mul_a = 32'(diff_reg);
                mul_b = 32'(alpha_reg);
            end
            MUL_FAC: begin
                if (bias_neg) begin
                    mul_a = 32'(OFF_LEVEL_GAIN);
                    mul_b = 32'(filt_reg);
                end else begin
                    mul_a = 32'(ON_HEADROOM_GAIN);
                    mul_b = 32'(Q16_ONE - {1'b0, filt_reg});
                end
            end
            MUL_BIAS: begin
                mul_a = 32'(bias_mag);
                mul_b = 32'(fac_reg);
            end
            MUL_DECAY: begin
                mul_a = 32'(bias_mag);
                mul_b = 32'(DECAY_ROM[dt_reg]);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // post-product helpers
    assign qs_sat     = prod_reg[32] ? 16'hFFFF : prod_reg[31:16];
    assign qs_half    = 16'(({1'b0, qs_sat} + 17'd1) >> 1);
    assign tgt_sum    = 18'(base_reg) + 18'(prod_reg[31:16])
                      + (aud_reg ? 18'(cfg.boost) : 18'd0);
    assign bias_d     = prod_reg[31:15];
    assign lvl_up     = 17'(filt_reg) + bias_d;
    assign decay_val  = prod_reg[45:30];
    // lvl * 1023 + half, as shift and subtract
    assign lvl_scaled = ({lvl_reg, 10'd0} - 26'(lvl_reg)) + LEVEL_ROUND;

    // model state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            filt_reg   <= '0;
            bias_reg   <= '0;
            seeded_reg <= 1'b0;
        end else if (cmd.load) begin
            case (s_req_type)
                REQ_ON:      bias_reg <= BIAS_ON;
                REQ_OFF:     bias_reg <= BIAS_OFF;
                REQ_RESTART: begin
                    bias_reg   <= '0;
                    seeded_reg <= 1'b0;
                end
                default: ;
            endcase
        end else begin
            case (cmd.wb_sel)
                WB_PHASE: phase_reg <= phase_reg + prod_reg[31:0];
                WB_FILT: begin
                    if (!seeded_reg) begin
                        filt_reg   <= tgt_reg;
                        seeded_reg <= 1'b1;
                    end else if (up_reg) begin
                        filt_reg <= filt_reg + prod_reg[31:16];
                    end else begin
                        filt_reg <= filt_reg - prod_reg[31:16];
                    end
                end
                WB_DECAY: begin
                    if (bias_mag > BIAS_FLOOR) begin
                        bias_reg <= bias_neg ? (16'd0 - decay_val) : decay_val;
                    end else begin
                        bias_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (cmd.load) begin
            dt_reg  <= dt_clamped;
            bp_reg  <= bp_clamped;
            aud_reg <= s_audio_playing;
        end
        case (cmd.wb_sel)
            WB_BMIN:  bsum_reg <= prod_reg[22:0];
            WB_BMAX:  bsum_reg <= bsum_reg + prod_reg[22:0];
            WB_T2:    t2_reg   <= prod_reg[32:16];
            WB_DIV:   base_reg <= prod_reg[45:30];
            WB_P1:    p_reg    <= SINE_C2 - prod_reg[32:16];
            WB_ALPHA: begin
                alpha_reg <= (prod_reg[22:0] > 23'(Q16_ONE)) ? Q16_ONE : prod_reg[16:0];
            end
            WB_P2:    p_reg    <= SINE_C1 - prod_reg[32:16];
            WB_P3:    p_reg    <= SINE_C0 - prod_reg[32:16];
            WB_WAVE: begin
                wave_reg <= phase_reg[31] ? (WAVE_MID - 17'(qs_half))
                                          : (WAVE_MID + 17'(qs_half));
            end
            WB_TGT:   tgt_reg  <= (tgt_sum > 18'h0FFFF) ? 16'hFFFF : tgt_sum[15:0];
            WB_ABS: begin
                if (tgt_reg >= filt_reg) begin
                    diff_reg <= tgt_reg - filt_reg;
                    up_reg   <= 1'b1;
                end else begin
                    diff_reg <= filt_reg - tgt_reg;
                    up_reg   <= 1'b0;
                end
            end
            WB_FAC: begin
                fac_reg <= (bias_neg ? OFF_MIN_DELTA : ON_MIN_DELTA) + prod_reg[31:16];
            end
            WB_LVL: begin
                if (bias_pos) begin
                    lvl_reg <= lvl_up[16] ? 16'hFFFF : lvl_up[15:0];
                end else if (bias_neg) begin
                    lvl_reg <= (bias_d >= 17'(filt_reg)) ? 16'd0
                                                         : (filt_reg - bias_d[15:0]);
                end else begin
                    lvl_reg <= filt_reg;
                end
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            out_reg <= lvl_scaled[25:16];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_stall = m_valid_reg & ~m_ready;
    assign m_valid          = m_valid_reg;
    assign m_drive_level    = out_reg;

endmodule

`default_nettype wire

@@ hdl/backlight_breathing_generator.sv @@
// ----------------------------------------------------------------------------
// backlight_breathing_generator
// Tick: runs the 24-step schedule on the single shared 32x32 multiplier;
//   no new item is taken until the schedule is back in idle.
// Toggle and restart: taken without leaving idle, no result.
// A finished result waits in the output register while the next item enters.
// Reset (aresetn, synchronous, active low): registers to defaults, phase,
//   filter and bias to zero, filter unseeded, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module backlight_breathing_generator
    import bbg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int FIRST_TICK_MS   = FIRST_TICK_MS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // item input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_req_type,
    input  wire logic [7:0]            s_elapsed_ms,
    input  wire logic [6:0]            s_brightness_percent,
    input  wire logic                  s_audio_playing,
    // result output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [9:0]            m_drive_level,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Config registers; the user must write them only between items (not enforced)
    bbg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: one state per multiplier issue / retire slot
    bbg_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: phase, sine polynomial, base/target, filter, bias, output
    bbg_dp #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .FIRST_TICK_MS   (FIRST_TICK_MS)
    ) u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg                  (cfg),
        .s_req_type           (s_req_type),
        .s_elapsed_ms         (s_elapsed_ms),
        .s_brightness_percent (s_brightness_percent),
        .s_audio_playing      (s_audio_playing),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_drive_level        (m_drive_level)
    );

endmodule

`default_nettype wire

@@ hdl/bbg_checker.sv @@
// ----------------------------------------------------------------------------
// bbg_checker
// Port-level checks of the breathing generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bbg_checker
    import bbg_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [1:0] s_req_type,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [9:0] m_drive_level
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_drive_level)))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // toggles and restarts finish in the accept cycle
    a_cmd_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type != REQ_TICK)) |=> s_ready)
        else $error("not ready after toggle or restart");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_TICK)) |=> !s_ready)
        else $error("ready while a tick is in progress");

    // with the output free at accept, a tick result becomes valid after the full schedule
    a_tick_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_TICK) && !m_valid) |-> ##25 m_valid)
        else $error("tick result missing at expected cycle");

endmodule

bind backlight_breathing_generator bbg_checker u_bbg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_drive_level (m_drive_level)
);

`default_nettype wire
